### rtl/core/jsu_pkg.sv
// shared types and constants for the json string unescape block
// no dependencies
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN  = 3'd1;
    localparam logic [2:0] ERR_ESC_END  = 3'd2;
    localparam logic [2:0] ERR_SHORT_U  = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd4;
    localparam logic [2:0] ERR_UNK_ESC  = 3'd5;
    localparam logic [2:0] ERR_UNCLOSED = 3'd6;

    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  CONT_BYTE    = 8'h80;
    localparam logic [7:0]  CONT_MASK    = 8'h3F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       run_end;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_count;
        logic [15:0] code_point;
    } t_state;

    typedef struct packed {
        t_state     state;
        logic [1:0] count;
        t_result    res2;
        t_result    res1;
        t_result    res0;
    } t_step;

endpackage

### rtl/core/jsu_decode.sv
// next state and result words for one input byte
// depends on jsu_pkg
module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  logic [7:0]      i_in_byte,
    input  logic            i_final_byte,
    output jsu_pkg::t_step  o_step
);
    import jsu_pkg::*;

    localparam t_state IDLE_STATE = '{mode: MODE_WAIT, hex_count: 2'd0, code_point: 16'd0};

    logic       w_hex_ok;
    logic [3:0] w_hex_val;
    logic       w_esc_ok;
    logic [7:0] w_esc_val;
    logic [15:0] w_cp;

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        case (i_in_byte) inside
            ["0":"9"]: w_hex_val = 4'(i_in_byte - 8'h30);
            ["a":"f"]: w_hex_val = 4'(i_in_byte - 8'h57);
            ["A":"F"]: w_hex_val = 4'(i_in_byte - 8'h37);
            default:   w_hex_ok  = 1'b0;
        endcase
    end

    always_comb begin
        w_esc_ok  = 1'b1;
        w_esc_val = i_in_byte;
        case (i_in_byte)
            "\"":    w_esc_val = 8'h22;
            "\\":    w_esc_val = 8'h5C;
            "/":     w_esc_val = 8'h2F;
            "n":     w_esc_val = 8'h0A;
            "r":     w_esc_val = 8'h0D;
            "t":     w_esc_val = 8'h09;
            "b":     w_esc_val = 8'h08;
            "f":     w_esc_val = 8'h0C;
            default: w_esc_ok  = 1'b0;
        endcase
    end

    assign w_cp = {i_state.code_point[11:0], w_hex_val};

    always_comb begin
        o_step       = '0;
        o_step.state = i_state;
        case (i_state.mode)
            MODE_WAIT: begin
                if (i_in_byte != "\"") begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_NO_OPEN, 1'b1};
                end else if (i_final_byte) begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_UNCLOSED, 1'b1};
                end else begin
                    o_step.state.mode = MODE_STR;
                end
            end
            MODE_STR: begin
                if (i_in_byte == "\"") begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_CLOSE, ERR_NONE, 1'b1};
                    o_step.state = IDLE_STATE;
                end else if (i_in_byte == "\\") begin
                    if (i_final_byte) begin
                        o_step.count = 2'd1;
                        o_step.res0  = '{8'd0, KIND_ERROR, ERR_ESC_END, 1'b1};
                    end else begin
                        o_step.state.mode = MODE_ESC;
                    end
                end else if (i_final_byte) begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_UNCLOSED, 1'b1};
                end else begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{i_in_byte, KIND_DATA, ERR_NONE, 1'b1};
                end
            end
            MODE_ESC: begin
                if (w_esc_ok) begin
                    o_step.count = 2'd1;
                    if (i_final_byte) begin
                        o_step.res0 = '{8'd0, KIND_ERROR, ERR_UNCLOSED, 1'b1};
                    end else begin
                        o_step.res0       = '{w_esc_val, KIND_DATA, ERR_NONE, 1'b1};
                        o_step.state.mode = MODE_STR;
                    end
                end else if (i_in_byte == "u") begin
                    if (i_final_byte) begin
                        o_step.count = 2'd1;
                        o_step.res0  = '{8'd0, KIND_ERROR, ERR_SHORT_U, 1'b1};
                    end else begin
                        o_step.state = '{mode: MODE_HEX, hex_count: 2'd0, code_point: 16'd0};
                    end
                end else begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_UNK_ESC, 1'b1};
                    o_step.state = IDLE_STATE;
                end
            end
            MODE_HEX: begin
                if (!w_hex_ok) begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_BAD_HEX, 1'b1};
                    o_step.state = IDLE_STATE;
                end else if (i_state.hex_count != 2'd3) begin
                    if (i_final_byte) begin
                        o_step.count = 2'd1;
                        o_step.res0  = '{8'd0, KIND_ERROR, ERR_SHORT_U, 1'b1};
                    end else begin
                        o_step.state.code_point = w_cp;
                        o_step.state.hex_count  = i_state.hex_count + 2'd1;
                    end
                end else if (i_final_byte) begin
                    o_step.count = 2'd1;
                    o_step.res0  = '{8'd0, KIND_ERROR, ERR_UNCLOSED, 1'b1};
                end else begin
                    o_step.state = '{mode: MODE_STR, hex_count: 2'd0, code_point: 16'd0};
                    if (w_cp < CP_ONE_LIMIT) begin
                        o_step.count = 2'd1;
                        o_step.res0  = '{w_cp[7:0], KIND_DATA, ERR_NONE, 1'b1};
                    end else if (w_cp < CP_TWO_LIMIT) begin
                        o_step.count = 2'd2;
                        o_step.res0  = '{LEAD_TWO | {3'd0, w_cp[10:6]},
                                         KIND_DATA, ERR_NONE, 1'b0};
                        o_step.res1  = '{CONT_BYTE | ({2'd0, w_cp[5:0]} & CONT_MASK),
                                         KIND_DATA, ERR_NONE, 1'b1};
                    end else begin
                        o_step.count = 2'd3;
                        o_step.res0  = '{LEAD_THREE | {4'd0, w_cp[15:12]},
                                         KIND_DATA, ERR_NONE, 1'b0};
                        o_step.res1  = '{CONT_BYTE | ({2'd0, w_cp[11:6]} & CONT_MASK),
                                         KIND_DATA, ERR_NONE, 1'b0};
                        o_step.res2  = '{CONT_BYTE | ({2'd0, w_cp[5:0]} & CONT_MASK),
                                         KIND_DATA, ERR_NONE, 1'b1};
                    end
                end
            end
            default: o_step.state = IDLE_STATE;
        endcase
        if (i_final_byte || o_step.res0.kind == KIND_ERROR) begin
            o_step.state = IDLE_STATE;
        end
    end

endmodule

### rtl/core/json_string_unescape_top.sv
// json string unescape top level: state registers and result buffer
// depends on jsu_pkg and jsu_decode
// the first result word of a byte is registered and offered in the cycle after the byte is accepted
// throughput: one input byte per cycle while each byte yields at most one word and the output is not stalled;
// a \u escape yields up to three words, drained one per cycle from the result buffer while the output is not stalled
// the next byte is taken in the cycle the last buffered word leaves
// reset (synchronous, active low) clears mode, hex count, code point and the buffer
module json_string_unescape_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic [2:0] o_error_code,
    output logic       o_run_end
);
    import jsu_pkg::*;

    t_state     r_state, n_state;
    t_result    r_res [MAX_RESULTS];
    t_result    n_res [MAX_RESULTS];
    logic [1:0] r_cnt, n_cnt;
    t_step      w_step;
    logic       w_in_take;
    logic       w_out_take;

    jsu_decode u_decode (
        .i_state      (r_state),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .o_step       (w_step)
    );

    assign o_valid    = (r_cnt != 2'd0);
    assign w_out_take = o_valid && !i_stall;
    assign o_stall    = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_out_take));
    assign w_in_take  = i_valid && !o_stall;

    assign o_out_byte   = r_res[0].out_byte;
    assign o_kind       = r_res[0].kind;
    assign o_error_code = r_res[0].error_code;
    assign o_run_end    = r_res[0].run_end;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        if (w_in_take) begin
            n_state  = w_step.state;
            n_cnt    = w_step.count;
            n_res[0] = w_step.res0;
            n_res[1] = w_step.res1;
            n_res[2] = w_step.res2;
        end else if (w_out_take) begin
            n_cnt    = r_cnt - 2'd1;
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_WAIT, hex_count: 2'd0, code_point: 16'd0};
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // last buffered word closes the run
    a_last_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cnt == 2'd1) |-> o_run_end)
        else $error("last buffered word lacks run_end");

    // close and error words stand alone
    a_single_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_DATA) |-> (r_cnt == 2'd1 && o_out_byte == 8'd0))
        else $error("control word not alone or carries data");

    // draining without refill drops exactly one word
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && !w_in_take) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("buffer count wrong after drain");

    // error words always report a code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERROR) |-> (o_error_code != ERR_NONE))
        else $error("error word without code");

endmodule

### tb/jsu_unescape_monitor.sv
// watches both channels of the json string unescape block, predicts every result word
// and compares it field by field with what the block delivers
// depends on jsu_pkg
module jsu_unescape_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_out_kind,
    input  logic [2:0] i_out_error_code,
    input  logic       i_out_run_end,
    output int         o_fail_count,
    output int         o_pending
);
    import jsu_pkg::*;

    t_mode       text_mode;
    logic [1:0]  digits_seen;
    logic [15:0] partial_cp;
    t_result     expected_words[$];
    int          mismatches = 0;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic int escape_target(input logic [7:0] c);
        case (c)
            "\"": return 8'h22;
            "\\": return 8'h5C;
            "/": return 8'h2F;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            "b": return 8'h08;
            "f": return 8'h0C;
            default: return -1;
        endcase
    endfunction

    function automatic t_result make_word(input logic [7:0] b, input logic [1:0] k,
                                          input logic [2:0] err);
        t_result w;
        w.out_byte   = b;
        w.kind       = k;
        w.error_code = err;
        w.run_end    = 1'b0;
        return w;
    endfunction

    task automatic decode_text_byte(input logic [7:0] c, input logic last);
        t_result     words[$];
        int          d;
        int          e;
        logic [15:0] cp;
        logic        failed;
        logic [2:0]  err;
        failed = 1'b0;
        err    = ERR_NONE;
        case (text_mode)
            MODE_WAIT: begin
                if (c != "\"") begin
                    failed = 1'b1;
                    err    = ERR_NO_OPEN;
                end else if (last) begin
                    failed = 1'b1;
                    err    = ERR_UNCLOSED;
                end else begin
                    text_mode = MODE_STR;
                end
            end
            MODE_STR: begin
                if (c == "\"") begin
                    words = {words, make_word(8'h00, KIND_CLOSE, ERR_NONE)};
                    text_mode = MODE_WAIT;
                end else if (c == "\\") begin
                    if (last) begin
                        failed = 1'b1;
                        err    = ERR_ESC_END;
                    end else begin
                        text_mode = MODE_ESC;
                    end
                end else if (last) begin
                    failed = 1'b1;
                    err    = ERR_UNCLOSED;
                end else begin
                    words = {words, make_word(c, KIND_DATA, ERR_NONE)};
                end
            end
            MODE_ESC: begin
                e = escape_target(c);
                if (e >= 0) begin
                    if (last) begin
                        failed = 1'b1;
                        err    = ERR_UNCLOSED;
                    end else begin
                        words = {words, make_word(e[7:0], KIND_DATA, ERR_NONE)};
                        text_mode = MODE_STR;
                    end
                end else if (c == "u") begin
                    if (last) begin
                        failed = 1'b1;
                        err    = ERR_SHORT_U;
                    end else begin
                        text_mode   = MODE_HEX;
                        digits_seen = 2'd0;
                        partial_cp  = 16'h0000;
                    end
                end else begin
                    failed = 1'b1;
                    err    = ERR_UNK_ESC;
                end
            end
            default: begin
                d  = hex_nibble(c);
                cp = {partial_cp[11:0], d[3:0]};
                if (d < 0) begin
                    failed = 1'b1;
                    err    = ERR_BAD_HEX;
                end else if (digits_seen != 2'd3) begin
                    if (last) begin
                        failed = 1'b1;
                        err    = ERR_SHORT_U;
                    end else begin
                        partial_cp  = cp;
                        digits_seen = digits_seen + 2'd1;
                    end
                end else if (last) begin
                    failed = 1'b1;
                    err    = ERR_UNCLOSED;
                end else begin
                    if (cp < CP_ONE_LIMIT) begin
                        words = {words, make_word(cp[7:0], KIND_DATA, ERR_NONE)};
                    end else if (cp < CP_TWO_LIMIT) begin
                        words = {words, make_word(LEAD_TWO | 8'(cp >> 6), KIND_DATA,
                                                  ERR_NONE)};
                        words = {words, make_word(CONT_BYTE | (cp[7:0] & CONT_MASK),
                                                  KIND_DATA, ERR_NONE)};
                    end else begin
                        words = {words, make_word(LEAD_THREE | 8'(cp >> 12), KIND_DATA,
                                                  ERR_NONE)};
                        words = {words, make_word(CONT_BYTE | (8'(cp >> 6) & CONT_MASK),
                                                  KIND_DATA, ERR_NONE)};
                        words = {words, make_word(CONT_BYTE | (cp[7:0] & CONT_MASK),
                                                  KIND_DATA, ERR_NONE)};
                    end
                    text_mode   = MODE_STR;
                    digits_seen = 2'd0;
                    partial_cp  = 16'h0000;
                end
            end
        endcase
        if (failed) begin
            words.delete();
            words = {words, make_word(8'h00, KIND_ERROR, err)};
        end
        if (failed || last) begin
            text_mode   = MODE_WAIT;
            digits_seen = 2'd0;
            partial_cp  = 16'h0000;
        end
        if (words.size() > 0) words[words.size() - 1].run_end = 1'b1;
        expected_words = {expected_words, words};
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            text_mode   = MODE_WAIT;
            digits_seen = 2'd0;
            partial_cp  = 16'h0000;
            expected_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall) decode_text_byte(i_in_byte, i_in_final);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: out_byte %0h kind %0d error_code %0d run_end %0d",
                           i_out_byte, i_out_kind, i_out_error_code, i_out_run_end);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.out_byte, i_out_byte);
                        mismatches++;
                    end
                    if (i_out_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_out_kind);
                        mismatches++;
                    end
                    if (i_out_error_code !== want.error_code) begin
                        $error("error_code mismatch: expected %0d, actual %0d",
                               want.error_code, i_out_error_code);
                        mismatches++;
                    end
                    if (i_out_run_end !== want.run_end) begin
                        $error("run_end mismatch: expected %0d, actual %0d",
                               want.run_end, i_out_run_end);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_json_string_unescape_top.sv
// testbench top for json_string_unescape_top: feeds directed and random string texts
// with random gaps and output stalls, then reports the verdict
// depends on jsu_pkg, json_string_unescape_top and jsu_unescape_monitor
module tb_json_string_unescape_top;
    import jsu_pkg::*;

    localparam int RANDOM_BYTES = 130;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 12;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_text_byte;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic [2:0] o_error_code;
    logic       o_run_end;

    int         fail_count;
    int         words_pending;
    int         idle_cycles = 0;
    logic       calm_in     = 1'b0;
    logic       calm_out    = 1'b0;
    t_text_byte text_bytes[$];
    logic [7:0] esc_chars[8] = '{"\"", "\\", "/", "n", "r", "t", "b", "f"};

    json_string_unescape_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_run_end    (o_run_end)
    );

    jsu_unescape_monitor mon (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_in_byte),
        .i_in_final       (i_final_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_out_kind       (o_kind),
        .i_out_error_code (o_error_code),
        .i_out_run_end    (o_run_end),
        .o_fail_count     (fail_count),
        .o_pending        (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_escape(input logic [7:0] c);
        foreach (esc_chars[i]) if (c == esc_chars[i]) return 1'b1;
        return c == "u";
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return "0" + 8'(nib);
        return (upper ? "A" : "a") + 8'(nib) - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_text_byte t;
        t.b    = b;
        t.last = last;
        text_bytes = {text_bytes, t};
    endtask

    task automatic push_digits(input logic [15:0] cp, input int count, input logic last_on_end);
        for (int i = 0; i < count; i++) begin
            push_byte(hex_char(cp[15 - 4 * i -: 4], 1'($urandom_range(0, 1))),
                      last_on_end && i == count - 1);
        end
    endtask

    function automatic logic [15:0] pick_code_point();
        logic [15:0] edges[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDFFF));
            4: return edges[$urandom_range(0, 5)];
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom); while (c == "\"" || c == "\\");
        return c;
    endfunction

    task automatic add_broken_tail();
        logic [7:0] c;
        int         k;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 6))
            0: push_byte("\\", 1'b1);
            1: begin
                push_byte("\\", 1'b0);
                push_byte("u", k == 0);
                push_digits(pick_code_point(), k, 1'b1);
            end
            2: begin
                push_byte("\\", 1'b0);
                push_byte("u", 1'b0);
                push_digits(pick_code_point(), k, 1'b0);
                do c = 8'($urandom); while (is_hex(c));
                push_byte(c, 1'($urandom_range(0, 1)));
            end
            3: begin
                push_byte("\\", 1'b0);
                do c = 8'($urandom); while (is_escape(c));
                push_byte(c, 1'($urandom_range(0, 1)));
            end
            4: push_byte(pick_plain(), 1'b1);
            5: begin
                push_byte("\\", 1'b0);
                push_byte(esc_chars[$urandom_range(0, 7)], 1'b1);
            end
            default: begin
                push_byte("\\", 1'b0);
                push_byte("u", 1'b0);
                push_digits(pick_code_point(), 4, 1'b1);
            end
        endcase
    endtask

    task automatic add_string();
        logic [7:0] c;
        int         parts;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do c = 8'($urandom); while (c == "\"");
                push_byte(c, $urandom_range(0, 3) == 0);
            end
        end
        push_byte("\"", 1'b0);
        parts = $urandom_range(0, 6);
        for (int p = 0; p < parts; p++) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: push_byte(pick_plain(), 1'b0);
                4, 5: begin
                    push_byte("\\", 1'b0);
                    push_byte(esc_chars[$urandom_range(0, 7)], 1'b0);
                end
                6, 7, 8, 9: begin
                    push_byte("\\", 1'b0);
                    push_byte("u", 1'b0);
                    push_digits(pick_code_point(), 4, 1'b0);
                end
                default: begin
                    add_broken_tail();
                    return;
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) push_byte("\"", $urandom_range(0, 3) == 0);
    endtask

    task automatic build_text();
        int directed_len;
        // byte extremes, the largest code point and every error code
        push_byte("x", 1'b0);
        push_byte("\"", 1'b1);
        push_byte("\"", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte("\\", 1'b0);
        push_byte("t", 1'b0);
        push_byte("\\", 1'b0);
        push_byte("u", 1'b0);
        push_digits(16'hFFFF, 4, 1'b0);
        push_byte("\"", 1'b0);
        push_byte("\"", 1'b0);
        push_byte("\\", 1'b1);
        push_byte("\"", 1'b0);
        push_byte("\\", 1'b0);
        push_byte("u", 1'b1);
        push_byte("\"", 1'b0);
        push_byte("\\", 1'b0);
        push_byte("u", 1'b0);
        push_byte("g", 1'b0);
        push_byte("\"", 1'b0);
        push_byte("\\", 1'b0);
        push_byte("q", 1'b0);
        push_byte("\"", 1'b0);
        push_byte("a", 1'b1);
        directed_len = text_bytes.size();
        while (text_bytes.size() < directed_len + RANDOM_BYTES) add_string();
    endtask

    // input side
    initial begin
        int gap;
        build_text();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (text_bytes[i]) begin
            if ($urandom_range(0, 24) == 0) calm_in = ~calm_in;
            gap = pick_gap(calm_in);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid      <= 1'b1;
            i_in_byte    <= text_bytes[i].b;
            i_final_byte <= text_bytes[i].last;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // output side
    initial begin
        int gap;
        forever begin
            if ($urandom_range(0, 19) == 0) calm_out = ~calm_out;
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            gap = pick_gap(calm_out);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
